>>> rtl/nls_pkg.sv
// shared widths, constants and sequencer types of the natural log block
package nls_pkg;

  localparam int VAL_W   = 64;            // operand width
  localparam int LOG_W   = 38;            // result width
  localparam int QF      = 40;            // fractional bits of the inner arithmetic
  localparam int MW      = 42;            // mantissa, up to 2.0 in Q.40
  localparam int ZW      = 41;            // magnitudes up to 1.0 in Q.40
  localparam int DW      = 42;            // divider denominator, up to 3.0 in Q.40
  localparam int KW      = 6;             // normalize shift count
  localparam int LZW     = 6;             // leading zero count of a 64-bit word
  localparam int LZ_STEPS = 6;            // binary search steps of the zero count
  localparam int KLN_W   = 46;            // k * ln2 in Q.40
  localparam int SUM_W   = 45;            // series sum
  localparam int TOT_W   = 48;            // signed Q.40 total
  localparam int ODD_W   = 5;             // odd series divisor, up to 31
  localparam int CHUNK_W = 8;             // dividend bits per cycle of the odd divider
  localparam int CHUNKS  = 6;             // dividend chunks of the odd divider
  localparam int PLO_W   = 21;            // low slice of the multiplier operand
  localparam int PROD_W  = ZW + PLO_W;    // partial product
  localparam int ACC_W   = 2 * ZW - 1;    // full product of two Q.40 magnitudes

  localparam logic [MW-1:0]  Q_ONE   = MW'(1) << QF;
  localparam logic [QF-1:0]  LN2_Q40 = 40'hB17217F7D2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LZC,
    ST_K,
    ST_M,
    ST_PREP,
    ST_DIV,
    ST_DIV_W,
    ST_SQ,
    ST_SQ_W,
    ST_TDIV,
    ST_TDIV_W,
    ST_FINAL,
    ST_RES,
    ST_OUT
  } nls_state_t;

  typedef enum logic [1:0] {
    MP_IDLE,
    MP_LO,
    MP_HI,
    MP_ACC
  } nls_mul_ph_t;

endpackage

>>> rtl/nls_div.sv
// restoring divider, one quotient bit a cycle, gives floor(num * 2^40 / den)
module nls_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [nls_pkg::ZW-1:0]  num,
  input  logic [nls_pkg::DW-1:0]  den,
  output logic                    done,
  output logic [nls_pkg::ZW-1:0]  quo
);
  import nls_pkg::*;

  localparam int STEPS = QF;
  localparam int CW    = $clog2(STEPS + 1);

  logic [DW-1:0] den_r, den_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [ZW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic [DW-1:0] num_x;
  logic          ge0;

  always_comb begin
    num_x    = DW'(num);
    ge0      = num_x >= den;
    trial    = {rem_r, 1'b0};
    diff     = trial - {1'b0, den_r};
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      // integer part is 0 or 1 since num never exceeds den
      den_nxt = den;
      rem_nxt = ge0 ? num_x - den : num_x;
      quo_nxt = ZW'(ge0);
      cnt_nxt = CW'(STEPS);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DW-1:0];
        quo_nxt = {quo_r[ZW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        quo_nxt = {quo_r[ZW-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> rtl/nls_mul.sv
// shared Q.40 multiplier: one 41x21 multiplier used over two slices, floor(a*b / 2^40)
module nls_mul (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [nls_pkg::ZW-1:0]  a,
  input  logic [nls_pkg::ZW-1:0]  b,
  output logic                    done,
  output logic [nls_pkg::ZW-1:0]  res
);
  import nls_pkg::*;

  nls_mul_ph_t       ph_r, ph_nxt;
  logic [ZW-1:0]     a_r, a_nxt;
  logic [ZW-1:0]     b_r, b_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              done_r, done_nxt;
  logic [PLO_W-1:0]  bsel;
  logic [PROD_W-1:0] pprod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= MP_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
  end

  always_comb begin
    bsel     = (ph_r == MP_LO) ? b_r[PLO_W-1:0] : PLO_W'(b_r[ZW-1:PLO_W]);
    pprod    = {{PLO_W{1'b0}}, a_r} * {{ZW{1'b0}}, bsel};
    ph_nxt   = ph_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    unique case (ph_r)
      MP_IDLE: begin
        if (start) begin
          a_nxt  = a;
          b_nxt  = b;
          ph_nxt = MP_LO;
        end
      end
      MP_LO: begin
        prod_nxt = pprod;
        ph_nxt   = MP_HI;
      end
      MP_HI: begin
        acc_nxt  = ACC_W'(prod_r);
        prod_nxt = pprod;
        ph_nxt   = MP_ACC;
      end
      MP_ACC: begin
        // high slice weighs 2^21
        acc_nxt  = acc_r + (ACC_W'(prod_r) << PLO_W);
        done_nxt = 1'b1;
        ph_nxt   = MP_IDLE;
      end
      default: ph_nxt = MP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign done = done_r;
  assign res  = acc_r[ACC_W-1:QF];

endmodule

>>> rtl/nls_odd_div.sv
// divider by a small odd number, eight dividend bits a cycle
module nls_odd_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [nls_pkg::ZW-1:0]    dividend,
  input  logic [nls_pkg::ODD_W-1:0] divisor,
  output logic                      done,
  output logic [nls_pkg::ZW-1:0]    quo
);
  import nls_pkg::*;

  localparam int DVD_W = CHUNK_W * CHUNKS;
  localparam int CW    = $clog2(CHUNKS + 1);

  logic [DVD_W-1:0]   dvd_r, dvd_nxt;
  logic [DVD_W-1:0]   quo_r, quo_nxt;
  logic [ODD_W-1:0]   r_r, r_nxt;
  logic [ODD_W-1:0]   d_r, d_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic [ODD_W-1:0]   r;
  logic [ODD_W:0]     x;
  logic [CHUNK_W-1:0] qb;
  logic [CHUNK_W-1:0] chunk;

  always_comb begin
    r     = r_r;
    x     = '0;
    qb    = '0;
    chunk = dvd_r[DVD_W-1 -: CHUNK_W];
    // partial remainder stays below the divisor
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      x = {r, chunk[i]};
      if (x >= {1'b0, d_r}) begin
        x     = x - {1'b0, d_r};
        qb[i] = 1'b1;
      end
      r = x[ODD_W-1:0];
    end

    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt = DVD_W'(dividend);
      quo_nxt = '0;
      r_nxt   = '0;
      d_nxt   = divisor;
      cnt_nxt = CW'(CHUNKS);
    end else if (cnt_r != '0) begin
      dvd_nxt  = dvd_r << CHUNK_W;
      quo_nxt  = {quo_r[DVD_W-CHUNK_W-1:0], qb};
      r_nxt    = r;
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    r_r   <= r_nxt;
    d_r   <= d_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r[ZW-1:0];

endmodule

>>> rtl/natural_log_series.sv
// natural log of a signed fixed point operand by the atanh series, under a small sequencer
// the result register is fed after 40 one-bit restoring divider steps, then one pass of the
//   odd divider per series term
// a zero or negative operand skips the series and goes straight to the output state
// a new request is taken only in idle, once the last result has been handed to the output
// reset (rst_n, synchronous, active low) clears the sequencer state, counters and out_valid only
module natural_log_series #(
  parameter int SERIES_TERMS = 5,
  parameter int FRAC_BITS    = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [nls_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [nls_pkg::LOG_W-1:0]  out_log_value,
  output logic                              out_invalid
);
  import nls_pkg::*;

  localparam int TW  = (SERIES_TERMS > 1) ? $clog2(SERIES_TERMS) : 1;
  localparam int RSH = (FRAC_BITS <= QF) ? QF - FRAC_BITS : 0;
  localparam int LSH = (FRAC_BITS > QF) ? FRAC_BITS - QF : 0;
  localparam logic [LOG_W-1:0] NEG_ONE = LOG_W'(64'd0 - (64'd1 << FRAC_BITS));

  nls_state_t         state_r, state_nxt;
  logic [VAL_W-1:0]   v_r, v_nxt;
  logic [VAL_W-1:0]   sh_r, sh_nxt;
  logic [LZW-1:0]     lz_r, lz_nxt;
  logic [2:0]         step_r, step_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [MW-1:0]      m_r, m_nxt;
  logic               zneg_r, zneg_nxt;
  logic [ZW-1:0]      num_r, num_nxt;
  logic [DW-1:0]      den_r, den_nxt;
  logic [KLN_W-1:0]   kln2_r, kln2_nxt;
  logic [ZW-1:0]      term_r, term_nxt;
  logic [ZW-1:0]      z2_r, z2_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [TW-1:0]      idx_r, idx_nxt;
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic [LOG_W-1:0]   res_log_r, res_log_nxt;
  logic               inv_r, inv_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LOG_W-1:0]   out_log_r, out_log_nxt;
  logic               out_inv_r, out_inv_nxt;

  logic               div_start, div_done;
  logic [ZW-1:0]      div_quo;
  logic               mul_start, mul_done;
  logic [ZW-1:0]      mul_res;
  logic               odd_start, odd_done;
  logic [ZW-1:0]      odd_quo;

  logic               zero_hi;
  logic [LZW-1:0]     amt;
  logic [LZW-1:0]     msb;
  logic [KW:0]        fk;
  logic [SUM_W:0]     two_sum;
  logic               neg;
  logic [TOT_W-1:0]   total_abs;
  logic [VAL_W-1:0]   mag_sh;
  logic               out_free;

  nls_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  nls_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (term_r),
    .b     (z2_r),
    .done  (mul_done),
    .res   (mul_res)
  );

  nls_odd_div u_odd (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (odd_start),
    .dividend (term_r),
    .divisor  (ODD_W'({idx_r, 1'b1})),
    .done     (odd_done),
    .quo      (odd_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    v_nxt         = v_r;
    sh_nxt        = sh_r;
    lz_nxt        = lz_r;
    step_nxt      = step_r;
    k_nxt         = k_r;
    m_nxt         = m_r;
    zneg_nxt      = zneg_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    kln2_nxt      = kln2_r;
    term_nxt      = term_r;
    z2_nxt        = z2_r;
    sum_nxt       = sum_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    res_log_nxt   = res_log_r;
    inv_nxt       = inv_r;
    out_log_nxt   = out_log_r;
    out_inv_nxt   = out_inv_r;
    div_start     = 1'b0;
    mul_start     = 1'b0;
    odd_start     = 1'b0;
    zero_hi       = 1'b0;
    amt           = '0;
    msb           = '0;
    fk            = '0;
    two_sum       = '0;
    neg           = 1'b0;
    total_abs     = '0;
    mag_sh        = '0;
    in_stall      = (state_r != ST_IDLE);
    out_free      = !out_valid_r || !out_stall;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          v_nxt    = in_value;
          sh_nxt   = $unsigned(in_value) - 64'd1;
          lz_nxt   = '0;
          step_nxt = '0;
          if (in_value[VAL_W-1] || in_value == '0) begin
            inv_nxt     = 1'b1;
            res_log_nxt = NEG_ONE;
            state_nxt   = ST_OUT;
          end else begin
            inv_nxt   = 1'b0;
            state_nxt = ST_LZC;
          end
        end
      end
      ST_LZC: begin
        // binary search for the leading one of value-1
        case (step_r)
          3'd0: begin zero_hi = (sh_r[63:32] == '0); amt = 6'd32; end
          3'd1: begin zero_hi = (sh_r[63:48] == '0); amt = 6'd16; end
          3'd2: begin zero_hi = (sh_r[63:56] == '0); amt = 6'd8;  end
          3'd3: begin zero_hi = (sh_r[63:60] == '0); amt = 6'd4;  end
          3'd4: begin zero_hi = (sh_r[63:62] == '0); amt = 6'd2;  end
          3'd5: begin zero_hi = !sh_r[63];           amt = 6'd1;  end
          default: begin zero_hi = 1'b0; amt = '0; end
        endcase
        if (zero_hi) begin
          sh_nxt = sh_r << amt;
          lz_nxt = lz_r + amt;
        end
        step_nxt = step_r + 1'b1;
        if (step_r == 3'(LZ_STEPS - 1)) begin
          state_nxt = ST_K;
        end
      end
      ST_K: begin
        // value <= 2^(FRAC_BITS+1+k) for the smallest such k
        msb       = 6'd63 - lz_r;
        k_nxt     = (msb > 6'(FRAC_BITS)) ? msb - 6'(FRAC_BITS) : '0;
        state_nxt = ST_M;
      end
      ST_M: begin
        fk = 7'(FRAC_BITS) + {1'b0, k_r};
        if (fk <= 7'(QF)) begin
          m_nxt = MW'(v_r << (7'(QF) - fk));
        end else begin
          m_nxt = MW'(v_r >> (fk - 7'(QF)));
        end
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        zneg_nxt  = m_r < Q_ONE;
        num_nxt   = (m_r < Q_ONE) ? ZW'(Q_ONE - m_r) : ZW'(m_r - Q_ONE);
        den_nxt   = m_r + Q_ONE;
        kln2_nxt  = KLN_W'(k_r) * KLN_W'(LN2_Q40);
        sum_nxt   = '0;
        idx_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_W;
      end
      ST_DIV_W: begin
        if (div_done) begin
          term_nxt  = div_quo;
          z2_nxt    = div_quo;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        mul_start = 1'b1;
        state_nxt = ST_SQ_W;
      end
      ST_SQ_W: begin
        if (mul_done) begin
          z2_nxt    = mul_res;
          state_nxt = ST_TDIV;
        end
      end
      ST_TDIV: begin
        // next odd power runs alongside the division of this one
        odd_start = 1'b1;
        mul_start = 1'b1;
        state_nxt = ST_TDIV_W;
      end
      ST_TDIV_W: begin
        // the multiplier always finishes before the odd divider
        if (mul_done) begin
          term_nxt = mul_res;
        end
        if (odd_done) begin
          sum_nxt = sum_r + SUM_W'(odd_quo);
          if (idx_r == TW'(SERIES_TERMS - 1)) begin
            state_nxt = ST_FINAL;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_TDIV;
          end
        end
      end
      ST_FINAL: begin
        two_sum = {sum_r, 1'b0};
        if (zneg_r) begin
          total_nxt = TOT_W'(kln2_r) - TOT_W'(two_sum);
        end else begin
          total_nxt = TOT_W'(kln2_r) + TOT_W'(two_sum);
        end
        state_nxt = ST_RES;
      end
      ST_RES: begin
        // magnitude is cut to the output scale, so truncation is toward zero
        neg         = total_r[TOT_W-1];
        total_abs   = neg ? TOT_W'(0) - total_r : total_r;
        mag_sh      = (VAL_W'(total_abs) >> RSH) << LSH;
        res_log_nxt = neg ? LOG_W'(64'd0 - mag_sh) : LOG_W'(mag_sh);
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_log_nxt   = res_log_r;
          out_inv_nxt   = inv_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    v_r       <= v_nxt;
    sh_r      <= sh_nxt;
    lz_r      <= lz_nxt;
    k_r       <= k_nxt;
    m_r       <= m_nxt;
    zneg_r    <= zneg_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    kln2_r    <= kln2_nxt;
    term_r    <= term_nxt;
    z2_r      <= z2_nxt;
    sum_r     <= sum_nxt;
    total_r   <= total_nxt;
    res_log_r <= res_log_nxt;
    inv_r     <= inv_nxt;
    out_log_r <= out_log_nxt;
    out_inv_r <= out_inv_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_log_value = out_log_r;
  assign out_invalid   = out_inv_r;

endmodule
